/* sv/soft_knee_compressor_gain_core_macros.svh */
// assertion macros for the soft knee compressor gain core
`ifndef SOFT_KNEE_COMPRESSOR_GAIN_CORE_MACROS_SVH
`define SOFT_KNEE_COMPRESSOR_GAIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SKC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skc assertion failed");
`define SKC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skc assertion failed");
`else
`define SKC_ASSERT_IMPL(name, ante, cons)
`define SKC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* sv/skc_pkg.sv */
// shared types, constants and tables of the soft knee compressor gain core
package skc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_W      = 56;
  localparam int DEN_W      = 43;
  localparam int QUO_W      = 16;

  localparam logic signed [15:0] DB_SILENT       = -16'sd25600;
  localparam logic [43:0]        DB_PER_LOG2_Q16 = 44'd394566;
  localparam logic [43:0]        LOG2_PER_DB_Q24 = 44'd2786635;
  localparam logic [19:0]        OUT_MAX         = 20'hFFFFF;
  localparam logic [17:0]        EXP_ONE         = 18'd65536;

  localparam logic [14:0] THRESHOLD_RST = 15'h6C00;
  localparam logic [12:0] RATIO_RST     = 13'd1024;
  localparam logic [12:0] KNEE_RST      = 13'd1536;
  localparam logic [12:0] MAKEUP_RST    = 13'd0;
  localparam logic [15:0] ATTACK_RST    = 16'd62000;
  localparam logic [15:0] RELEASE_RST   = 16'd65000;
  localparam logic [1:0]  CHANNELS_RST  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_RATIO     = 3'd1,
    CFG_KNEE      = 3'd2,
    CFG_MAKEUP    = 3'd3,
    CFG_ATTACK    = 3'd4,
    CFG_RELEASE   = 3'd5,
    CFG_CHANNELS  = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_SQ, ST_DB, ST_XR, ST_RED, ST_UU, ST_UA, ST_UN,
    ST_HNUM, ST_DSTART, ST_DWAIT, ST_SMUL, ST_SUPD, ST_Q, ST_EMUL,
    ST_ESPLIT, ST_ELOOP, ST_PROD, ST_SH1, ST_SH2, ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic [19:0]        out_level;
    logic signed [15:0] gain_reduction_db;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [15:0] rect16(input logic signed [15:0] v);
    logic [16:0] neg;
    neg = 17'h10000 - {1'b0, v};
    return v[15] ? neg[15:0] : v;
  endfunction

  function automatic logic [3:0] lead_one(input logic [15:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction

  // 2^(2^-k)-1 in q16, k = 1..16
  function automatic logic [14:0] exp_coef(input logic [3:0] idx);
    logic [14:0] c;
    unique case (idx)
      4'd0:  c = 15'd27146;
      4'd1:  c = 15'd12400;
      4'd2:  c = 15'd5932;
      4'd3:  c = 15'd2902;
      4'd4:  c = 15'd1435;
      4'd5:  c = 15'd714;
      4'd6:  c = 15'd356;
      4'd7:  c = 15'd178;
      4'd8:  c = 15'd89;
      4'd9:  c = 15'd44;
      4'd10: c = 15'd22;
      4'd11: c = 15'd11;
      4'd12: c = 15'd6;
      4'd13: c = 15'd3;
      4'd14: c = 15'd1;
      4'd15: c = 15'd1;
      default: c = 15'd0;
    endcase
    return c;
  endfunction

endpackage

/* sv/skc_div.sv */
// iterative restoring divider, one quotient bit per cycle
module skc_div import skc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic [3:0]       step;
  logic [NUM_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] quot;
  logic             done;
  logic [DEN_W+QUO_W-1:0] den_sh;
  logic [DEN_W+QUO_W-1:0] rem_ext;
  logic                   fits;

  always_comb begin
    den_sh  = {{QUO_W{1'b0}}, den} << step;
    rem_ext = {{(DEN_W+QUO_W-NUM_W){1'b0}}, rem};
    fits    = rem_ext >= den_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.num;
        den  <= req.den;
        quot <= '0;
        step <= 4'hF;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem        <= rem - den_sh[NUM_W-1:0];
          quot[step] <= 1'b1;
        end
        step <= step - 4'd1;
        if (step == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* sv/soft_knee_compressor_gain_core.sv */
// Soft knee compressor gain core: one stereo sample pair in, one gain-applied level and
// one gain reduction meter value out. The block works on one item at a time with a single
// shared 20x44 multiplier under a sequencer. in_ready stays low from acceptance until the
// sequencer is back in idle. An item inside the knee takes longest, then one above it, then
// one below it. A silent level skips the log loop. The 16-step log2 squaring loop, the
// divider and the 16-step exponent loop set how long an item takes. A finished result waits
// in the output register while the next item is accepted. If the previous result is still
// held there, the sequencer waits in its last step until it is taken. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
`include "soft_knee_compressor_gain_core_macros.svh"
module soft_knee_compressor_gain_core import skc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic signed [14:0] thr;
  logic [12:0]        ratio;
  logic [12:0]        knee;
  logic [12:0]        makeup;
  logic [15:0]        att;
  logic [15:0]        rel;
  logic [1:0]         chans;

  state_t state, state_next;

  logic [15:0]        level_r;
  logic [16:0]        m_log;
  logic [3:0]         p_r;
  logic [15:0]        f_log;
  logic [3:0]         cnt;
  logic [63:0]        prod_r;
  logic signed [15:0] x_r;
  logic signed [17:0] diff_r;
  logic [13:0]        u_r;
  logic [DEN_W-1:0]   den_r;
  logic               neg_r;
  logic signed [16:0] g_r;
  logic signed [31:0] dstate;
  logic signed [15:0] meter_r;
  logic signed [26:0] s_r;
  logic signed [16:0] exp_n;
  logic [15:0]        exp_f;
  logic [17:0]        exp_m;
  logic [56:0]        sum_r;
  logic [5:0]         amt_r;
  logic               sat_r;
  logic               zero_r;
  logic [19:0]        res_level;

  logic [15:0]        la, ra, in_level;
  logic [16:0]        lvl_sum;
  logic [3:0]         lead;
  logic [33:0]        sq;
  logic [19:0]        mag_db;
  logic [39:0]        xr_sum;
  logic signed [19:0] x2, t2, kk, lo, hi, u;
  logic signed [17:0] diff;
  logic [17:0]        diff_mag;
  logic [12:0]        r_eff, rr;
  logic signed [33:0] g256, dd, q2, dnew;
  logic [33:0]        dd_mag;
  logic [15:0]        coef;
  logic [47:0]        q2_sum;
  logic [32:0]        dmag;
  logic [32:0]        qa_sum;
  logic signed [25:0] q, mq;
  logic signed [15:0] meter;
  logic signed [26:0] s_val;
  logic [26:0]        s_mag;
  logic [47:0]        e_sum;
  logic signed [32:0] e_val;
  logic signed [16:0] nsh;
  logic [5:0]         amt;
  logic [56:0]        rnd, sum_val, v;
  logic               sat_val, zero_val;
  logic [35:0]        et;
  logic [19:0]        mul_a;
  logic [43:0]        mul_b;
  logic [63:0]        mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  skc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THRESHOLD_RST;
      ratio  <= RATIO_RST;
      knee   <= KNEE_RST;
      makeup <= MAKEUP_RST;
      att    <= ATTACK_RST;
      rel    <= RELEASE_RST;
      chans  <= CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_THRESHOLD: thr    <= cfg_data[14:0];
        CFG_RATIO:     ratio  <= cfg_data[12:0];
        CFG_KNEE:      knee   <= cfg_data[12:0];
        CFG_MAKEUP:    makeup <= cfg_data[12:0];
        CFG_ATTACK:    att    <= cfg_data;
        CFG_RELEASE:   rel    <= cfg_data;
        CFG_CHANNELS:  chans  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // datapath arithmetic
  always_comb begin
    la       = rect16(in_item.left_sample);
    ra       = rect16(in_item.right_sample);
    lvl_sum  = {1'b0, la} + {1'b0, ra};
    in_level = (chans == 2'd1) ? la : lvl_sum[16:1];
    lead     = lead_one(level_r);
    sq       = mul_p[33:0];
    mag_db   = {4'(4'd15 - p_r), 16'b0} - {4'b0, f_log};
    xr_sum   = prod_r[39:0] + 40'h800000;

    x2 = {{3{x_r[15]}}, x_r, 1'b0};
    t2 = {{4{thr[14]}}, thr, 1'b0};
    kk = {7'b0, knee};
    lo = t2 - kk;
    hi = t2 + kk;
    u  = x2 - lo;
    diff     = {{3{thr[14]}}, thr} - {{2{x_r[15]}}, x_r};
    diff_mag = diff_r[17] ? 18'(-diff_r) : 18'(diff_r);
    r_eff    = (ratio < 13'd256) ? 13'd256 : ratio;
    rr       = r_eff - 13'd256;

    g256   = {{9{g_r[16]}}, g_r, 8'b0};
    dd     = {{2{dstate[31]}}, dstate} - g256;
    dd_mag = dd[33] ? 34'(-dd) : 34'(dd);
    coef   = (!dd[33] && (dd != '0)) ? att : rel;
    q2_sum = prod_r[47:0] + 48'd32768;
    q2     = {2'b0, q2_sum[47:16]};
    dnew   = g256 + (neg_r ? -q2 : q2);

    dmag   = dstate[31] ? 33'(-{dstate[31], dstate}) : {1'b0, dstate};
    qa_sum = dmag + 33'd128;
    q      = dstate[31] ? -$signed({1'b0, qa_sum[32:8]}) : $signed({1'b0, qa_sum[32:8]});
    mq     = -q;
    if (mq > 26'sd32767) begin
      meter = 16'sd32767;
    end else if (mq < -26'sd32768) begin
      meter = -16'sd32768;
    end else begin
      meter = mq[15:0];
    end
    s_val = {q[25], q} + $signed({14'b0, makeup});
    s_mag = s_r[26] ? 27'(-s_r) : 27'(s_r);

    e_sum = prod_r[47:0] + 48'd32768;
    e_val = s_r[26] ? -$signed({1'b0, e_sum[47:16]}) : $signed({1'b0, e_sum[47:16]});

    sat_val  = exp_n > 17'sd20;
    zero_val = (level_r == '0) || (exp_n < -17'sd20);
    nsh      = 17'sd36 - exp_n;
    amt      = nsh[5:0];
    rnd      = 57'd1 << (amt - 6'd1);
    sum_val  = {2'b0, prod_r[34:0], 20'b0} + rnd;
    v        = sum_r >> amt_r;
    et       = mul_p[35:0] + 36'd32768;
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ: begin
        mul_a = {3'b0, m_log};
        mul_b = {27'b0, m_log};
      end
      ST_DB: begin
        mul_a = mag_db;
        mul_b = DB_PER_LOG2_Q16;
      end
      ST_UU: begin
        mul_a = {6'b0, u_r};
        mul_b = {30'b0, u_r};
      end
      ST_UA: begin
        mul_a = {7'b0, rr};
        mul_b = prod_r[43:0];
      end
      ST_UN: begin
        mul_a = {2'b0, diff_mag};
        mul_b = prod_r[43:0];
      end
      ST_HNUM: begin
        mul_a = {2'b0, diff_mag};
        mul_b = {31'b0, rr};
      end
      ST_SMUL: begin
        mul_a = {4'b0, coef};
        mul_b = {10'b0, dd_mag};
      end
      ST_EMUL: begin
        mul_a = s_mag[19:0];
        mul_b = LOG2_PER_DB_Q24;
      end
      ST_ELOOP: begin
        mul_a = {5'b0, exp_coef(cnt)};
        mul_b = {26'b0, exp_m};
      end
      ST_PROD: begin
        mul_a = {4'b0, level_r};
        mul_b = {26'b0, exp_m};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = (state == ST_IDLE);
    div_req.start = (state == ST_DSTART);
    div_req.num   = prod_r[NUM_W-1:0] + {{(NUM_W-DEN_W+1){1'b0}}, den_r[DEN_W-1:1]};
    div_req.den   = den_r;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_NORM;
      ST_NORM:   state_next = (level_r == '0) ? ST_RED : ST_SQ;
      ST_SQ:     if (cnt == 4'hF) state_next = ST_DB;
      ST_DB:     state_next = ST_XR;
      ST_XR:     state_next = ST_RED;
      ST_RED: begin
        if (x2 < lo) begin
          state_next = ST_SMUL;
        end else if (x2 < hi) begin
          state_next = ST_UU;
        end else begin
          state_next = ST_HNUM;
        end
      end
      ST_UU:     state_next = ST_UA;
      ST_UA:     state_next = ST_UN;
      ST_UN:     state_next = ST_DSTART;
      ST_HNUM:   state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (div_rsp.done) state_next = ST_SMUL;
      ST_SMUL:   state_next = ST_SUPD;
      ST_SUPD:   state_next = ST_Q;
      ST_Q:      state_next = ST_EMUL;
      ST_EMUL:   state_next = ST_ESPLIT;
      ST_ESPLIT: state_next = ST_ELOOP;
      ST_ELOOP:  if (cnt == 4'hF) state_next = ST_PROD;
      ST_PROD:   state_next = ST_SH1;
      ST_SH1:    state_next = ST_SH2;
      ST_SH2:    state_next = ST_OUT;
      ST_OUT:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate    <= '0;
      out_valid <= 1'b0;
    end else begin
      prod_r <= mul_p;
      if (out_valid && out_ready && (state != ST_OUT)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) level_r <= in_level;
        ST_NORM: begin
          if (level_r == '0) begin
            x_r <= DB_SILENT;
          end else begin
            p_r   <= lead;
            m_log <= {1'b0, level_r} << (5'd16 - {1'b0, lead});
            f_log <= '0;
            cnt   <= '0;
          end
        end
        ST_SQ: begin
          m_log <= sq[33] ? sq[33:17] : sq[32:16];
          f_log <= {f_log[14:0], sq[33]};
          cnt   <= cnt + 4'd1;
        end
        ST_XR: x_r <= -$signed(xr_sum[39:24]);
        ST_RED: begin
          diff_r <= diff;
          u_r    <= u[13:0];
          if (x2 < lo) g_r <= '0;
        end
        ST_UN: begin
          den_r <= prod_r[DEN_W-1:0] + (DEN_W'(knee) << 19);
          neg_r <= diff_r[17];
        end
        ST_HNUM: begin
          den_r <= DEN_W'(r_eff);
          neg_r <= diff_r[17];
        end
        ST_DWAIT: begin
          if (div_rsp.done) begin
            g_r <= neg_r ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
          end
        end
        ST_SMUL: neg_r <= dd[33];
        ST_SUPD: dstate <= dnew[31:0];
        ST_Q: begin
          meter_r <= meter;
          s_r     <= s_val;
        end
        ST_ESPLIT: begin
          exp_n <= e_val[32:16];
          exp_f <= e_val[15:0];
          exp_m <= EXP_ONE;
          cnt   <= '0;
        end
        ST_ELOOP: begin
          if (exp_f[4'hF - cnt]) exp_m <= exp_m + et[33:16];
          cnt <= cnt + 4'd1;
        end
        ST_SH1: begin
          sum_r  <= sum_val;
          amt_r  <= amt;
          sat_r  <= sat_val;
          zero_r <= zero_val;
        end
        ST_SH2: begin
          if (zero_r) begin
            res_level <= '0;
          end else if (sat_r || (v > 57'(OUT_MAX))) begin
            res_level <= OUT_MAX;
          end else begin
            res_level <= v[19:0];
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid                  <= 1'b1;
            out_item.out_level         <= res_level;
            out_item.gain_reduction_db <= meter_r;
          end
        end
        default: ;
      endcase
    end
  end

  `SKC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SKC_ASSERT_IMPL(a_div_done_in_wait, div_rsp.done, state == ST_DWAIT)
  `SKC_ASSERT_IMPL(a_log_mant_norm, state == ST_SQ, m_log[16])
  `SKC_ASSERT_IMPL(a_exp_mant_floor, state == ST_ELOOP, exp_m >= EXP_ONE)

endmodule
